[design/zaes_pkg.sv]
// Shared types and constants for the ZIP audio entry scanner.
`timescale 1ns / 1ps

package zaes_pkg;

    // ZIP record signatures as they appear in a little-endian 32-bit window
    localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
    localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
    localparam logic [31:0] SIG_END     = 32'h06054b50;

    // Local header length and the byte positions of its fields
    localparam logic [31:0] HEADER_LEN  = 32'd30;
    localparam logic [4:0]  HDR_SIG_END = 5'd4;
    localparam logic [4:0]  HDR_CSIZE   = 5'd18;
    localparam logic [4:0]  HDR_USIZE   = 5'd22;
    localparam logic [4:0]  HDR_NLEN    = 5'd26;
    localparam logic [4:0]  HDR_ELEN    = 5'd28;
    localparam logic [4:0]  HDR_LAST    = 5'd29;

    // Lower-cased name tails that are accepted
    localparam logic [31:0] TAIL_MP3 = 32'h2E6D7033;
    localparam logic [31:0] TAIL_WAV = 32'h2E776176;
    localparam logic [31:0] TAIL_OGG = 32'h2E6F6767;

    // Result kinds
    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_COUNT  = 2'd3;

    // Depth of the command queue between parser and result sequencer
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_SCAN   = 3'd0,
        PH_HEADER = 3'd1,
        PH_NAME   = 3'd2,
        PH_SKIP   = 3'd3,
        PH_STOP   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_archive;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_byte;
        logic [31:0] data_offset;
        logic [31:0] file_size;
        logic        is_mp3;
        logic [15:0] name_length;
        logic [31:0] entry_count;
        logic        last_of_run;
    } out_item_t;

    // Everything one archive byte causes, handed from parser to sequencer
    typedef struct packed {
        logic        has_name;
        logic [7:0]  name_byte;
        logic        has_decision;
        logic        accepted;
        logic [31:0] data_offset;
        logic [31:0] file_size;
        logic        is_mp3;
        logic [15:0] name_length;
        logic        has_count;
        logic [31:0] entry_count;
    } cmd_t;

    // Fold ASCII upper case to lower case, leave every other byte alone
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

[design/zip_audio_entry_scanner_unit.sv]
// Path: the command for an accepted byte is written to the queue, then loaded into the
// sequencer's current-command register, from which its results are offered.
// Throughput: one byte per cycle while the queue is not full; a byte that causes two
// or three results sends them in turn, and a four-entry command queue absorbs those bursts.
// Reset (rst_n, asynchronous, active low) puts the parser at offset zero scanning for a
// signature, empties the queue and drops any pending result.
`timescale 1ns / 1ps

module zip_audio_entry_scanner_unit
#(
    parameter int QUEUE_DEPTH = zaes_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  zaes_pkg::in_item_t  byte_data,
    output logic                result_valid,
    input  logic                result_stall,
    output zaes_pkg::out_item_t result_data
);

    logic           byte_fire;
    logic           q_push, q_full, q_pop, q_not_empty;
    zaes_pkg::cmd_t front_cmd, q_cmd;

    // Hold the byte channel while the queue is full
    assign byte_stall = q_full;
    assign byte_fire  = byte_valid && !byte_stall;

    zaes_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (byte_fire),
        .item  (byte_data),
        .push  (q_push),
        .cmd   (front_cmd)
    );

    zaes_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_cmd)
    );

    zaes_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_not_empty),
        .cmd          (q_cmd),
        .cmd_pop      (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

[design/zaes_front.sv]
// Byte parser: signature search, header capture, name tracking and skip.
`timescale 1ns / 1ps

module zaes_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  zaes_pkg::in_item_t item,
    output logic               push,
    output zaes_pkg::cmd_t     cmd
);

    zaes_pkg::phase_t phase_reg, phase_next;
    logic [31:0] win_reg, win_next;
    logic [2:0]  fill_reg, fill_next;
    logic [4:0]  hidx_reg, hidx_next;
    logic [31:0] hstart_reg, hstart_next;
    logic [31:0] pos_reg, pos_next;
    logic [15:0] nlen_reg, nlen_next;
    logic [15:0] elen_reg, elen_next;
    logic [31:0] csize_reg, csize_next;
    logic [31:0] usize_reg, usize_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] tail_reg, tail_next;
    logic [31:0] count_reg, count_next;

    logic [7:0]  b;
    logic        last;
    logic        stop_hit, local_hit, hdr_done, nlen_zero, name_done, skip_done;
    logic        finish, skip_nz, tail_ok, tail_mp3;
    logic [31:0] offset;

    assign b    = item.data_byte;
    assign last = item.end_of_archive;

    // Datapath and command for the byte in flight
    always_comb
    begin
        win_next    = win_reg;
        fill_next   = fill_reg;
        hidx_next   = hidx_reg;
        hstart_next = hstart_reg;
        pos_next    = pos_reg;
        nlen_next   = nlen_reg;
        elen_next   = elen_reg;
        csize_next  = csize_reg;
        usize_next  = usize_reg;
        rem_next    = rem_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        stop_hit    = 1'b0;
        local_hit   = 1'b0;
        hdr_done    = 1'b0;
        name_done   = 1'b0;
        skip_done   = 1'b0;
        finish      = 1'b0;
        cmd         = '0;

        if (fire)
        begin
            case (phase_reg)
                zaes_pkg::PH_SCAN:
                begin
                    // Slide the window and look for a signature
                    win_next = {b, win_reg[31:8]};
                    if (fill_reg != 3'd4)
                    begin
                        fill_next = fill_reg + 3'd1;
                    end
                    if (fill_next == 3'd4)
                    begin
                        if (win_next == zaes_pkg::SIG_CENTRAL || win_next == zaes_pkg::SIG_END)
                        begin
                            stop_hit = 1'b1;
                        end
                        else if (win_next == zaes_pkg::SIG_LOCAL)
                        begin
                            local_hit   = 1'b1;
                            hstart_next = pos_reg - 32'd3;
                            hidx_next   = zaes_pkg::HDR_SIG_END;
                            csize_next  = '0;
                            usize_next  = '0;
                            nlen_next   = '0;
                            elen_next   = '0;
                        end
                    end
                end
                zaes_pkg::PH_HEADER:
                begin
                    // Capture the size and length fields byte by byte
                    if (hidx_reg >= zaes_pkg::HDR_CSIZE && hidx_reg < zaes_pkg::HDR_USIZE)
                    begin
                        csize_next[{hidx_reg[1:0] - 2'd2, 3'b000} +: 8] = b;
                    end
                    else if (hidx_reg >= zaes_pkg::HDR_USIZE && hidx_reg < zaes_pkg::HDR_NLEN)
                    begin
                        usize_next[{hidx_reg[1:0] - 2'd2, 3'b000} +: 8] = b;
                    end
                    else if (hidx_reg >= zaes_pkg::HDR_NLEN && hidx_reg < zaes_pkg::HDR_ELEN)
                    begin
                        nlen_next[{hidx_reg[0], 3'b000} +: 8] = b;
                    end
                    else if (hidx_reg >= zaes_pkg::HDR_ELEN && hidx_reg <= zaes_pkg::HDR_LAST)
                    begin
                        elen_next[{hidx_reg[0], 3'b000} +: 8] = b;
                    end
                    if (hidx_reg >= zaes_pkg::HDR_LAST)
                    begin
                        hdr_done  = 1'b1;
                        hidx_next = '0;
                        tail_next = '0;
                        if (nlen_next == 16'd0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            rem_next = {16'd0, nlen_next};
                        end
                    end
                    else
                    begin
                        hidx_next = hidx_reg + 5'd1;
                    end
                end
                zaes_pkg::PH_NAME:
                begin
                    // Pass the name byte on and keep the folded tail
                    tail_next     = {tail_reg[23:0], zaes_pkg::fold_case(b)};
                    cmd.has_name  = 1'b1;
                    cmd.name_byte = b;
                    rem_next      = rem_reg - 32'd1;
                    if (rem_next == 32'd0)
                    begin
                        name_done = 1'b1;
                        finish    = 1'b1;
                    end
                end
                zaes_pkg::PH_SKIP:
                begin
                    // Drop extra field and compressed data
                    rem_next = rem_reg - 32'd1;
                    if (rem_next == 32'd0)
                    begin
                        skip_done = 1'b1;
                        win_next  = '0;
                        fill_next = '0;
                    end
                end
                default:
                begin
                end
            endcase

            // Decide the entry once its name is complete
            if (finish)
            begin
                cmd.has_decision = 1'b1;
                if (tail_ok)
                begin
                    count_next       = count_reg + 32'd1;
                    cmd.accepted     = 1'b1;
                    cmd.data_offset  = offset;
                    cmd.file_size    = usize_next;
                    cmd.is_mp3       = tail_mp3;
                    cmd.name_length  = nlen_next;
                end
                rem_next  = {16'd0, elen_next} + csize_next;
                win_next  = '0;
                fill_next = '0;
            end

            pos_next = pos_reg + 32'd1;

            // Final byte: report the count and start a new archive
            if (last)
            begin
                cmd.has_count   = 1'b1;
                cmd.entry_count = count_next;
                win_next        = '0;
                fill_next       = '0;
                hidx_next       = '0;
                hstart_next     = '0;
                pos_next        = '0;
                nlen_next       = '0;
                elen_next       = '0;
                csize_next      = '0;
                usize_next      = '0;
                rem_next        = '0;
                tail_next       = '0;
                count_next      = '0;
            end
        end
    end

    assign offset    = hstart_reg + zaes_pkg::HEADER_LEN + {16'd0, nlen_next}
                       + {16'd0, elen_next};
    assign tail_mp3  = (tail_next == zaes_pkg::TAIL_MP3);
    assign tail_ok   = tail_mp3 || tail_next == zaes_pkg::TAIL_WAV
                       || tail_next == zaes_pkg::TAIL_OGG;
    assign nlen_zero = (nlen_next == 16'd0);
    assign skip_nz   = ({16'd0, elen_next} + csize_next) != 32'd0;
    assign push      = cmd.has_name | cmd.has_decision | cmd.has_count;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            if (last)
            begin
                phase_next = zaes_pkg::PH_SCAN;
            end
            else
            begin
                case (phase_reg)
                    zaes_pkg::PH_SCAN:
                    begin
                        if (stop_hit)
                        begin
                            phase_next = zaes_pkg::PH_STOP;
                        end
                        else if (local_hit)
                        begin
                            phase_next = zaes_pkg::PH_HEADER;
                        end
                    end
                    zaes_pkg::PH_HEADER:
                    begin
                        if (hdr_done)
                        begin
                            if (!nlen_zero)
                            begin
                                phase_next = zaes_pkg::PH_NAME;
                            end
                            else if (skip_nz)
                            begin
                                phase_next = zaes_pkg::PH_SKIP;
                            end
                            else
                            begin
                                phase_next = zaes_pkg::PH_SCAN;
                            end
                        end
                    end
                    zaes_pkg::PH_NAME:
                    begin
                        if (name_done)
                        begin
                            phase_next = skip_nz ? zaes_pkg::PH_SKIP : zaes_pkg::PH_SCAN;
                        end
                    end
                    zaes_pkg::PH_SKIP:
                    begin
                        if (skip_done)
                        begin
                            phase_next = zaes_pkg::PH_SCAN;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= zaes_pkg::PH_SCAN;
            win_reg    <= '0;
            fill_reg   <= '0;
            hidx_reg   <= '0;
            hstart_reg <= '0;
            pos_reg    <= '0;
            nlen_reg   <= '0;
            elen_reg   <= '0;
            csize_reg  <= '0;
            usize_reg  <= '0;
            rem_reg    <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            win_reg    <= win_next;
            fill_reg   <= fill_next;
            hidx_reg   <= hidx_next;
            hstart_reg <= hstart_next;
            pos_reg    <= pos_next;
            nlen_reg   <= nlen_next;
            elen_reg   <= elen_next;
            csize_reg  <= csize_next;
            usize_reg  <= usize_next;
            rem_reg    <= rem_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    // The final byte always leaves the parser at the start of a new archive
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> phase_reg == zaes_pkg::PH_SCAN && pos_reg == 32'd0
                         && count_reg == 32'd0)
        else $error("parser did not restart after final byte");

    // A header is only ever entered from the scan phase on a local signature
    a_header_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(phase_reg == zaes_pkg::PH_HEADER) |-> hidx_reg == zaes_pkg::HDR_SIG_END)
        else $error("header capture started at wrong index");
`endif

endmodule

[design/zaes_queue.sv]
// Short command queue between parser and result sequencer.
`timescale 1ns / 1ps

module zaes_queue
#(
    parameter int DEPTH = zaes_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  zaes_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output zaes_pkg::cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    zaes_pkg::cmd_t        store_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = store_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write the command store
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    // The parser is held off before the queue can overflow
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

    // Occupancy tracks the pushes and pops
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue occupancy lost a push");
`endif

endmodule

[design/zaes_back.sv]
// Result sequencer: expands each command into one to three output transactions.
`timescale 1ns / 1ps

module zaes_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  zaes_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output zaes_pkg::out_item_t result_data
);

    zaes_pkg::cmd_t cur_reg, cur_next;
    logic [2:0]     pend_reg, pend_next;   // name, decision, count still to send
    logic           single, out_fire, advance;

    assign result_valid = (pend_reg != 3'b000);
    assign single       = ((pend_reg & (pend_reg - 3'd1)) == 3'b000);
    assign out_fire     = result_valid && !result_stall;
    assign advance      = !result_valid || (out_fire && single);
    assign cmd_pop      = advance && cmd_valid;

    // Load the next command or retire the transaction just sent
    always_comb
    begin
        cur_next  = cur_reg;
        pend_next = pend_reg;
        if (advance)
        begin
            if (cmd_valid)
            begin
                cur_next  = cmd;
                pend_next = {cmd.has_count, cmd.has_decision, cmd.has_name};
            end
            else
            begin
                pend_next = 3'b000;
            end
        end
        else if (out_fire)
        begin
            pend_next = pend_reg & (pend_reg - 3'd1);
        end
    end

    // Present the lowest pending result
    always_comb
    begin
        result_data             = '0;
        result_data.last_of_run = single;
        if (pend_reg[0])
        begin
            result_data.kind      = zaes_pkg::KIND_NAME;
            result_data.name_byte = cur_reg.name_byte;
        end
        else if (pend_reg[1])
        begin
            if (cur_reg.accepted)
            begin
                result_data.kind        = zaes_pkg::KIND_ACCEPT;
                result_data.data_offset = cur_reg.data_offset;
                result_data.file_size   = cur_reg.file_size;
                result_data.is_mp3      = cur_reg.is_mp3;
                result_data.name_length = cur_reg.name_length;
            end
            else
            begin
                result_data.kind = zaes_pkg::KIND_REJECT;
            end
        end
        else
        begin
            result_data.kind        = zaes_pkg::KIND_COUNT;
            result_data.entry_count = cur_reg.entry_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'b000;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

`ifndef SYNTHESIS
    // A stalled result keeps its pending set
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(pend_reg))
        else $error("pending results changed under stall");

    // A command is only taken once the current one has fully drained
    a_pop_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !result_valid || (out_fire && $onehot(pend_reg)))
        else $error("command popped while results still pending");
`endif

endmodule

[tb/zip_audio_entry_scanner_checker.sv]
// Checker that predicts the scanner's results from accepted bytes and compares them.
`timescale 1ns / 1ps

module zip_audio_entry_scanner_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic                byte_stall,
    input  zaes_pkg::in_item_t  byte_data,
    input  logic                result_valid,
    input  logic                result_stall,
    input  zaes_pkg::out_item_t result_data,
    output int                  fail_count,
    output int                  results_outstanding
);
    import zaes_pkg::*;

    // Mismatch lines printed before going quiet; counting goes on
    localparam int PRINT_LIMIT = 30;

    // Predicted scanner state
    phase_t      scan_phase;
    logic [31:0] sig_window;
    logic [2:0]  window_fill;
    logic [4:0]  hdr_index;
    logic [31:0] hdr_start;
    logic [31:0] byte_pos;
    logic [15:0] name_len;
    logic [15:0] extra_len;
    logic [31:0] comp_size;
    logic [31:0] uncomp_size;
    logic [31:0] bytes_left;
    logic [31:0] name_tail;
    logic [31:0] accepted_entries;

    out_item_t expected_results[$];
    int        results_checked;

    initial
    begin
        fail_count          = 0;
        results_outstanding = 0;
        results_checked     = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic clear_scanner_state();
        scan_phase       = PH_SCAN;
        sig_window       = '0;
        window_fill      = '0;
        hdr_index        = '0;
        hdr_start        = '0;
        byte_pos         = '0;
        name_len         = '0;
        extra_len        = '0;
        comp_size        = '0;
        uncomp_size      = '0;
        bytes_left       = '0;
        name_tail        = '0;
        accepted_entries = '0;
    endtask

    // Decide on the entry whose name just ended, then set up the skip
    task automatic decide_entry();
        out_item_t r;
        r = '0;
        if (name_tail == TAIL_MP3 || name_tail == TAIL_WAV || name_tail == TAIL_OGG)
        begin
            accepted_entries = accepted_entries + 1;
            r.kind        = KIND_ACCEPT;
            r.data_offset = hdr_start + HEADER_LEN + {16'h0, name_len} + {16'h0, extra_len};
            r.file_size   = uncomp_size;
            r.is_mp3      = (name_tail == TAIL_MP3);
            r.name_length = name_len;
        end
        else
        begin
            r.kind = KIND_REJECT;
        end
        expected_results.push_back(r);
        bytes_left  = {16'h0, extra_len} + comp_size;
        sig_window  = '0;
        window_fill = '0;
        scan_phase  = (bytes_left != 0) ? PH_SKIP : PH_SCAN;
    endtask

    // Advance the predicted state by one archive byte and queue what it causes
    task automatic scan_byte(input in_item_t item);
        logic [7:0] b;
        logic [7:0] folded;
        logic [4:0] i;
        int         queued_before;
        out_item_t  r;
        b             = item.data_byte;
        queued_before = expected_results.size();
        case (scan_phase)
            PH_SCAN:
            begin
                sig_window = {b, sig_window[31:8]};
                if (window_fill < 3'd4)
                begin
                    window_fill = window_fill + 3'd1;
                end
                if (window_fill == 3'd4)
                begin
                    if (sig_window == SIG_CENTRAL || sig_window == SIG_END)
                    begin
                        scan_phase = PH_STOP;
                    end
                    else if (sig_window == SIG_LOCAL)
                    begin
                        hdr_start   = byte_pos - 32'd3;
                        hdr_index   = HDR_SIG_END;
                        comp_size   = '0;
                        uncomp_size = '0;
                        name_len    = '0;
                        extra_len   = '0;
                        scan_phase  = PH_HEADER;
                    end
                end
            end
            PH_HEADER:
            begin
                i = hdr_index;
                if (i >= HDR_CSIZE && i < HDR_USIZE)
                begin
                    comp_size = comp_size | ({24'h0, b} << (8 * (i - HDR_CSIZE)));
                end
                else if (i >= HDR_USIZE && i < HDR_NLEN)
                begin
                    uncomp_size = uncomp_size | ({24'h0, b} << (8 * (i - HDR_USIZE)));
                end
                else if (i >= HDR_NLEN && i < HDR_ELEN)
                begin
                    name_len = name_len | ({8'h0, b} << (8 * (i - HDR_NLEN)));
                end
                else if (i >= HDR_ELEN && i <= HDR_LAST)
                begin
                    extra_len = extra_len | ({8'h0, b} << (8 * (i - HDR_ELEN)));
                end
                if (i >= HDR_LAST)
                begin
                    hdr_index = '0;
                    name_tail = '0;
                    if (name_len == 16'd0)
                    begin
                        decide_entry();
                    end
                    else
                    begin
                        bytes_left = {16'h0, name_len};
                        scan_phase = PH_NAME;
                    end
                end
                else
                begin
                    hdr_index = i + 5'd1;
                end
            end
            PH_NAME:
            begin
                // only A-Z fold; everything else passes as is
                folded    = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
                name_tail = {name_tail[23:0], folded};
                r           = '0;
                r.kind      = KIND_NAME;
                r.name_byte = b;
                expected_results.push_back(r);
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0)
                begin
                    decide_entry();
                end
            end
            PH_SKIP:
            begin
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0)
                begin
                    sig_window  = '0;
                    window_fill = '0;
                    scan_phase  = PH_SCAN;
                end
            end
            default:
            begin
                // stopped: drop the byte
            end
        endcase
        byte_pos = byte_pos + 32'd1;

        // Final byte: count comes last, then a fresh archive starts
        if (item.end_of_archive)
        begin
            r             = '0;
            r.kind        = KIND_COUNT;
            r.entry_count = accepted_entries;
            expected_results.push_back(r);
            clear_scanner_state();
        end

        // Mark the last result this byte caused
        if (expected_results.size() > queued_before)
        begin
            r             = expected_results.pop_back();
            r.last_of_run = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      results_checked, field, got, want));
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with none expected (kind %0d)",
                                      results_checked, got.kind));
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("kind", 32'(got.kind), 32'(want.kind));
            compare_field("name_byte", 32'(got.name_byte), 32'(want.name_byte));
            compare_field("data_offset", got.data_offset, want.data_offset);
            compare_field("file_size", got.file_size, want.file_size);
            compare_field("is_mp3", 32'(got.is_mp3), 32'(want.is_mp3));
            compare_field("name_length", 32'(got.name_length), 32'(want.name_length));
            compare_field("entry_count", got.entry_count, want.entry_count);
            compare_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
        end
        results_checked++;
    endtask

    // Predict on each accepted byte, then compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scanner_state();
            expected_results.delete();
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                scan_byte(byte_data);
            end
            if (result_valid && !result_stall)
            begin
                check_result(result_data);
            end
        end
        results_outstanding = expected_results.size();
    end

endmodule

[tb/zip_audio_entry_scanner_unit_test.sv]
// Top of the scanner testbench: clock, reset, archive stimulus and the verdict.
`timescale 1ns / 1ps

module zip_audio_entry_scanner_unit_test;
    import zaes_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 1;
    localparam int DRAIN_CYCLES = 20;

    // How the last four name bytes are chosen
    localparam int TAIL_PICK_MP3    = 0;
    localparam int TAIL_PICK_WAV    = 1;
    localparam int TAIL_PICK_OGG    = 2;
    localparam int TAIL_PICK_NEAR   = 3;
    localparam int TAIL_PICK_RANDOM = 4;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_data;
    logic      result_valid;
    logic      result_stall;
    out_item_t result_data;

    int fail_count;
    int results_outstanding;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_sent     = 0;

    in_item_t archive_bytes[$];

    zip_audio_entry_scanner_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    zip_audio_entry_scanner_checker scan_checker
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .byte_valid          (byte_valid),
        .byte_stall          (byte_stall),
        .byte_data           (byte_data),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .result_data         (result_data),
        .fail_count          (fail_count),
        .results_outstanding (results_outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("zip_audio_entry_scanner_unit_test NOT OK");
            $finish;
        end
    end

    task automatic put_byte(input logic [7:0] b);
        in_item_t item;
        item.data_byte      = b;
        item.end_of_archive = 1'b0;
        archive_bytes.push_back(item);
    endtask

    task automatic put_le(input logic [31:0] v, input int nbytes);
        for (int k = 0; k < nbytes; k++)
        begin
            put_byte(v[8*k +: 8]);
        end
    endtask

    task automatic put_random(input int nbytes);
        for (int k = 0; k < nbytes; k++)
        begin
            put_byte(8'($urandom_range(255)));
        end
    endtask

    // Append one local header, its name, extra field and data_len body bytes
    task automatic add_entry(input logic [15:0] nlen, input logic [15:0] elen,
                             input logic [31:0] csize, input logic [31:0] usize,
                             input int tail_pick, input int data_len);
        logic [31:0] tail_word;
        logic [7:0]  ch;
        int          pos;
        case (tail_pick)
            TAIL_PICK_MP3: tail_word = TAIL_MP3;
            TAIL_PICK_WAV: tail_word = TAIL_WAV;
            TAIL_PICK_OGG: tail_word = TAIL_OGG;
            default:
            begin
                case ($urandom_range(2))
                    0:       tail_word = TAIL_MP3;
                    1:       tail_word = TAIL_WAV;
                    default: tail_word = TAIL_OGG;
                endcase
            end
        endcase
        // near miss: spoil one byte of a good suffix
        if (tail_pick == TAIL_PICK_NEAR)
        begin
            tail_word[8*$urandom_range(3) +: 8] ^= 8'($urandom_range(1, 255));
        end
        put_le(SIG_LOCAL, 4);
        put_random(int'(HDR_CSIZE - HDR_SIG_END));
        put_le(csize, 4);
        put_le(usize, 4);
        put_le({16'h0, nlen}, 2);
        put_le({16'h0, elen}, 2);
        for (int k = 0; k < int'(nlen); k++)
        begin
            pos = k - (int'(nlen) - 4);
            if (pos >= 0 && tail_pick != TAIL_PICK_RANDOM)
            begin
                ch = tail_word[8*(3-pos) +: 8];
                if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(1) == 1)
                begin
                    ch = ch - 8'h20;
                end
                put_byte(ch);
            end
            else
            begin
                put_byte(8'($urandom_range(255)));
            end
        end
        put_random(int'(elen));
        put_random(data_len);
    endtask

    // Drive one transaction, with random idle cycles ahead of it
    task automatic send_byte(input in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= item;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        phase_sent++;
    endtask

    // Flag the final byte and send the whole archive
    task automatic send_archive();
        in_item_t item;
        item                = archive_bytes.pop_back();
        item.end_of_archive = 1'b1;
        archive_bytes.push_back(item);
        while (archive_bytes.size() > 0)
        begin
            item = archive_bytes.pop_front();
            send_byte(item);
        end
    endtask

    // Mostly well-formed archives with random content; some noise and cut-offs
    task automatic random_archive();
        int          entries;
        logic [15:0] nlen;
        logic [15:0] elen;
        logic [31:0] csize;
        int          data_len;
        bit          long_skip;
        int          keep;
        long_skip = 1'b0;
        if ($urandom_range(9) == 0)
        begin
            put_random($urandom_range(1, 12));
        end
        else
        begin
            entries = 1;
            for (int e = 0; e < entries; e++)
            begin
                put_random($urandom_range(0, 2));
                if ($urandom_range(7) == 0)
                begin
                    // a signature that falls one byte short
                    put_le(SIG_LOCAL, 3);
                    put_random(1);
                end
                case ($urandom_range(4))
                    0:       nlen = 16'd0;
                    1:       nlen = 16'($urandom_range(1, 3));
                    default: nlen = 16'($urandom_range(4, 9));
                endcase
                elen = 16'($urandom_range(0, 3));
                if ($urandom_range(9) == 0)
                begin
                    // extra plus size wraps to zero: no skip at all
                    csize    = 32'd0 - {16'h0, elen};
                    data_len = 0;
                end
                else
                begin
                    csize    = 32'($urandom_range(0, 4));
                    data_len = int'(csize);
                end
                if (e == entries - 1 && $urandom_range(7) == 0)
                begin
                    // huge body, archive ends inside the skip
                    long_skip = 1'b1;
                    csize     = $urandom() | 32'h100;
                    data_len  = $urandom_range(0, 4);
                end
                add_entry(nlen, elen, csize, $urandom(), $urandom_range(4), data_len);
            end
            if (!long_skip && $urandom_range(2) == 0)
            begin
                put_le(($urandom_range(1) == 1) ? SIG_CENTRAL : SIG_END, 4);
                put_random($urandom_range(0, 3));
                if ($urandom_range(1) == 1)
                begin
                    put_le(SIG_LOCAL, 4);
                    put_random($urandom_range(0, 30));
                end
            end
            if (!long_skip && $urandom_range(4) == 0)
            begin
                keep          = $urandom_range(1, archive_bytes.size());
                archive_bytes = archive_bytes[0:keep-1];
            end
        end
        send_archive();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_data    = '0;
        result_stall = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty archive: only the count comes out
        put_byte(8'hFF);
        send_archive();

        // Mixed archive: mp3 with full-scale size, empty name, wrapped skip on
        // an exact ".wav" name, random-case ogg, then an end signature with a
        // local header behind it that must be ignored
        put_byte(8'h00);
        add_entry(16'd5, 16'd2, 32'd3, 32'hFFFF_FFFF, TAIL_PICK_MP3, 3);
        add_entry(16'd0, 16'd0, 32'd0, 32'd0, TAIL_PICK_RANDOM, 0);
        add_entry(16'd4, 16'd1, 32'hFFFF_FFFF, 32'd0, TAIL_PICK_WAV, 0);
        add_entry(16'd7, 16'd0, 32'd0, 32'h8000_0000, TAIL_PICK_OGG, 0);
        put_le(SIG_END, 4);
        put_le(SIG_LOCAL, 4);
        put_random(3);
        send_archive();

        // Archive cut inside a name: name bytes stay tentative
        add_entry(16'd6, 16'd0, 32'd0, 32'd7, TAIL_PICK_OGG, 0);
        archive_bytes = archive_bytes[0:32];
        send_archive();

        // Random archives under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 54;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_BYTES)
            begin
                random_archive();
            end
        end

        // Drain: wait for every expected result, then watch for strays
        byte_valid <= 1'b0;
        @(negedge clk);
        while (results_outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("zip_audio_entry_scanner_unit_test OK");
        end
        else
        begin
            $display("zip_audio_entry_scanner_unit_test NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
design/zaes_pkg.sv
design/zaes_front.sv
design/zaes_queue.sv
design/zaes_back.sv
design/zip_audio_entry_scanner_unit.sv
tb/zip_audio_entry_scanner_checker.sv
tb/zip_audio_entry_scanner_unit_test.sv
